FILE: rtl/ascii_decimal_to_int16_core_macros.svh
// Assertion macros shared by the parser modules.
`ifndef ASCII_DECIMAL_TO_INT16_CORE_MACROS_SVH
`define ASCII_DECIMAL_TO_INT16_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ADI16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adi16 assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ADI16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adi16 assertion failed");
`else
`define ADI16_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ADI16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/adi16_pkg.sv
package adi16_pkg;

	localparam logic [7:0]  CH_MINUS   = 8'h2D;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;
	localparam logic [15:0] MAX_PREFIX = 16'(16'hFFFF / 10);
	localparam logic [3:0]  MAX_SUFFIX = 4'(16'hFFFF % 10);
	localparam logic [15:0] MAX_POS    = 16'hFFFF >> 1;
	localparam logic [15:0] MAX_NEG    = MAX_POS + 16'd1;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic [15:0] value_bits;
		logic        parse_ok;
	} result_t;

endpackage

FILE: rtl/adi16_in_stage.sv
module adi16_in_stage
	import adi16_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  char_beat_t in_beat,
	input  logic       advance,
	output logic       valid_s1,
	output char_beat_t beat_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

FILE: rtl/adi16_parse.sv
`include "ascii_decimal_to_int16_core_macros.svh"

module adi16_parse
	import adi16_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  char_beat_t beat,
	input  logic       signed_mode,
	output result_t    result
);

	logic [15:0] acc_q;
	logic        start_q;
	logic        neg_q;
	logic        seen_q;
	logic        fail_q;

	logic        is_digit;
	logic [3:0]  digit;
	logic        take_minus;
	logic        overflow;
	logic        digit_ok;
	logic [15:0] mac;
	logic [15:0] acc_next;
	logic        neg_next;
	logic        seen_next;
	logic        fail_next;
	logic        ok;
	logic [15:0] value;

	assign is_digit   = (beat.char_code >= CH_ZERO) && (beat.char_code <= CH_NINE);
	assign digit      = beat.char_code[3:0];
	assign take_minus = !fail_q && start_q && signed_mode && (beat.char_code == CH_MINUS);
	assign overflow   = (acc_q > MAX_PREFIX) || ((acc_q == MAX_PREFIX) && (digit > MAX_SUFFIX));
	assign digit_ok   = !fail_q && !take_minus && is_digit && !overflow;
	assign mac        = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'd0, digit};
	assign acc_next   = digit_ok ? mac : acc_q;
	assign neg_next   = neg_q || take_minus;
	assign seen_next  = seen_q || digit_ok;
	assign fail_next  = fail_q || (!take_minus && !digit_ok);

	always_comb begin
		ok    = !fail_next && seen_next;
		value = acc_next;
		if (neg_next) begin
			if (acc_next > MAX_NEG) begin
				ok = 1'b0;
			end
			value = 16'd0 - acc_next;
		end else if (signed_mode && (acc_next > MAX_POS)) begin
			ok = 1'b0;
		end
		result.parse_ok   = ok;
		result.value_bits = ok ? value : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 16'd0;
			start_q <= 1'b1;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else if (step_en) begin
			if (beat.last_char) begin
				acc_q   <= 16'd0;
				start_q <= 1'b1;
				neg_q   <= 1'b0;
				seen_q  <= 1'b0;
				fail_q  <= 1'b0;
			end else begin
				acc_q   <= acc_next;
				start_q <= 1'b0;
				neg_q   <= neg_next;
				seen_q  <= seen_next;
				fail_q  <= fail_next;
			end
		end
	end

	`ADI16_ASSERT_NEXT(a_clear_after_last, clk, arst_n, step_en && beat.last_char,
		start_q && !fail_q && !seen_q && !neg_q && (acc_q == 16'd0))
	`ADI16_ASSERT_NEXT(a_hold_after_fail, clk, arst_n, step_en && fail_q && !beat.last_char,
		fail_q && $stable(acc_q) && $stable(seen_q))
	`ADI16_ASSERT_NEXT(a_start_cleared, clk, arst_n, step_en && !beat.last_char, !start_q)

endmodule

FILE: rtl/adi16_out_stage.sv
`include "ascii_decimal_to_int16_core_macros.svh"

module adi16_out_stage
	import adi16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     result,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        free,
	output logic [15:0] value_bits,
	output logic        parse_ok
);

	logic    valid_q;
	result_t result_q;

	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign value_bits = result_q.value_bits;
	assign parse_ok   = result_q.parse_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			result_q <= result;
		end
	end

	`ADI16_ASSERT_NOW(a_failed_is_zero, clk, arst_n, valid_q && !result_q.parse_ok,
		result_q.value_bits == 16'd0)
	`ADI16_ASSERT_NOW(a_no_load_when_full, clk, arst_n, load, free)

endmodule

FILE: rtl/ascii_decimal_to_int16_core.sv
// Streaming ASCII decimal to 16-bit integer parser, one character per beat.
// A last character's beat is held in the input register, then its result in the result register.
// Throughput: one character per cycle; the only stall is a full result register.
// The per-character update is one combinational multiply-by-ten add and compare.
// Reset clears the parse state and sets signed_mode to unsigned; no clearing pass.
module ascii_decimal_to_int16_core
	import adi16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        signed_mode_we,
	input  logic        signed_mode_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] value_bits,
	output logic        parse_ok
);

	logic       signed_mode_q;
	char_beat_t in_beat;
	char_beat_t beat_s1;
	logic       valid_s1;
	logic       advance;
	logic       out_free;
	result_t    result;

	assign in_beat.char_code = char_code;
	assign in_beat.last_char = last_char;
	assign advance           = valid_s1 && (!beat_s1.last_char || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (signed_mode_we) begin
			signed_mode_q <= signed_mode_wdata;
		end
	end

	adi16_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	adi16_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.beat        (beat_s1),
		.signed_mode (signed_mode_q),
		.result      (result)
	);

	adi16_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && beat_s1.last_char),
		.result     (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.free       (out_free),
		.value_bits (value_bits),
		.parse_ok   (parse_ok)
	);

endmodule
